FILE: rtl/lca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_pkg: shared definitions for the life cellular automaton grid unit
// Grid geometry, field widths, opcodes, register addresses and sequencer states.
// ----------------------------------------------------------------------------
package lca_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int CFG_W    = 7;
   localparam int CNT_W    = 4;
   localparam int PADDR_W  = 3;

   localparam logic [PADDR_W-1:0] CSR_ADDR_WIDTH  = 3'd0;
   localparam logic [PADDR_W-1:0] CSR_ADDR_HEIGHT = 3'd4;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_ADV_LD0,
      ST_ADV_LD1,
      ST_ADV_CELL,
      ST_ADV_WB,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/life_cellular_automaton_grid_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid_unit: B3/S23 cell grid with single-cell access
// Row-wide grid memory, a one-cell rule unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | ports      | payload (low bit first)
//  --------+------------+----------------------------------------------------
//  request | req_t*     | opcode[1:0] col[7:2] row[13:8] cell_in[14], pad 0
//  result  | rsp_t*     | cell_out[0] out_of_range[1], pad 0
//  config  | csr_p*     | 0x0 width_in_use[6:0], 0x4 height_in_use[6:0]
//
//  Advance walks the single rule unit over the in-use area one cell per cycle,
//  plus a load and a write-back per row. Reset clears all row valid bits; no
//  clearing pass is needed. One request is in work at a time; a new one is
//  taken while the previous result waits in the output register, and the
//  sequencer holds its result until the output register is free.
// ----------------------------------------------------------------------------
module life_cellular_automaton_grid_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // opcode[1:0], col[7:2], row[13:8], cell_in[14], zero[15]
   input  logic [15:0]                  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // cell_out[0], out_of_range[1], zero[7:2]
   output logic [7:0]                   rsp_tdata,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lca_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int COLS = lca_pkg::MAX_COLS;
   localparam int ROWS = lca_pkg::MAX_ROWS;
   localparam int CW   = lca_pkg::COL_W;
   localparam int RW   = lca_pkg::ROW_W;
   localparam int FW   = lca_pkg::CFG_W;

   // request fields
   lca_pkg::opcode_type req_op;
   logic [CW-1:0]       req_col;
   logic [RW-1:0]       req_row;
   logic                req_cell;
   logic                req_fire;

   assign req_op   = lca_pkg::opcode_type'(req_tdata[1:0]);
   assign req_col  = req_tdata[2 +: CW];
   assign req_row  = req_tdata[2 + CW +: RW];
   assign req_cell = req_tdata[2 + CW + RW];
   assign req_fire = req_tvalid && req_tready;

   // configuration registers
   logic [FW-1:0] width_ff, height_ff;
   logic [FW-1:0] eff_w, eff_h;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FW'(64);
         height_ff <= FW'(64);
      end else if (csr_wr) begin
         if (csr_paddr == lca_pkg::CSR_ADDR_WIDTH) width_ff <= csr_pwdata[FW-1:0];
         if (csr_paddr == lca_pkg::CSR_ADDR_HEIGHT) height_ff <= csr_pwdata[FW-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr)
         lca_pkg::CSR_ADDR_WIDTH:  csr_prdata = {{(32-FW){1'b0}}, width_ff};
         lca_pkg::CSR_ADDR_HEIGHT: csr_prdata = {{(32-FW){1'b0}}, height_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // saturate to the grid size
   assign eff_w = (width_ff > FW'(COLS)) ? FW'(COLS) : width_ff;
   assign eff_h = (height_ff > FW'(ROWS)) ? FW'(ROWS) : height_ff;

   logic [COLS-1:0] col_mask;
   always_comb begin
      for (int i = 0; i < COLS; i++) col_mask[i] = (FW'(i) < eff_w);
   end

   // grid memory: one row per word, row valid bits stand in for clearing
   logic [COLS-1:0] grid_mem [ROWS];
   logic [ROWS-1:0] row_valid_ff, row_valid_in;
   logic [COLS-1:0] rdata_ff;
   logic            rd_valid_ff;
   logic [RW-1:0]   mem_raddr, mem_waddr;
   logic [COLS-1:0] mem_wdata;
   logic            mem_we;
   logic [COLS-1:0] row_data;

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
      rdata_ff <= grid_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= row_valid_ff[mem_raddr];
      end
   end

   assign row_data = rd_valid_ff ? rdata_ff : '0;

   // sequencer and datapath registers
   lca_pkg::state_type  state_ff, state_in;
   lca_pkg::opcode_type op_ff, op_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                cell_ff, cell_in;
   logic                res_cell_ff, res_cell_in;
   logic                res_oor_ff, res_oor_in;
   logic [COLS-1:0]     prev_ff, prev_in;
   logic [COLS-1:0]     cur_ff, cur_in;
   logic [COLS-1:0]     next_ff, next_in;
   logic [COLS-1:0]     next_raw_ff, next_raw_in;
   logic [COLS-1:0]     new_ff, new_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_data_ff, rsp_data_in;
   logic                rsp_load;

   logic            access_oor;
   logic            last_col, last_row;
   logic            next_row_in_area;
   logic [RW:0]     row_plus1, row_plus2;

   assign access_oor = ({1'b0, req_col} >= eff_w) || ({1'b0, req_row} >= eff_h);
   assign last_col   = ({1'b0, col_ff} == eff_w - FW'(1));
   assign last_row   = ({1'b0, row_ff} == eff_h - FW'(1));
   assign row_plus1  = {1'b0, row_ff} + (RW+1)'(1);
   assign row_plus2  = {1'b0, row_ff} + (RW+1)'(2);
   assign next_row_in_area = (FW'(row_plus1) < eff_h);
   assign rsp_load   = (state_ff == lca_pkg::ST_RESP) && (!rsp_valid_ff || rsp_tready);

   // shared rule unit: one cell from the three row buffers
   logic            nb_left_ok, nb_right_ok;
   logic [CW-1:0]   col_l, col_r;
   logic [lca_pkg::CNT_W-1:0] nb_count;
   logic            rule_out;

   assign nb_left_ok  = (col_ff != '0);
   assign nb_right_ok = (col_ff != CW'(COLS - 1));
   assign col_l       = col_ff - CW'(1);
   assign col_r       = col_ff + CW'(1);

   always_comb begin
      logic [7:0] nb;
      nb[0] = nb_left_ok  && prev_ff[col_l];
      nb[1] = prev_ff[col_ff];
      nb[2] = nb_right_ok && prev_ff[col_r];
      nb[3] = nb_left_ok  && cur_ff[col_l];
      nb[4] = nb_right_ok && cur_ff[col_r];
      nb[5] = nb_left_ok  && next_ff[col_l];
      nb[6] = next_ff[col_ff];
      nb[7] = nb_right_ok && next_ff[col_r];
      nb_count = '0;
      for (int i = 0; i < 8; i++) nb_count = nb_count + lca_pkg::CNT_W'(nb[i]);
   end

   // survive with 2 or 3, born with exactly 3
   assign rule_out = cur_ff[col_ff] ? ((nb_count == lca_pkg::CNT_W'(2)) ||
                                       (nb_count == lca_pkg::CNT_W'(3)))
                                    : (nb_count == lca_pkg::CNT_W'(3));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lca_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  lca_pkg::OP_WRITE, lca_pkg::OP_READ:
                     state_in = access_oor ? lca_pkg::ST_RESP : lca_pkg::ST_RD_WAIT;
                  lca_pkg::OP_ADVANCE:
                     state_in = (eff_w == '0 || eff_h == '0) ? lca_pkg::ST_RESP
                                                              : lca_pkg::ST_ADV_LD0;
                  default: state_in = lca_pkg::ST_RESP;
               endcase
            end
         end
         lca_pkg::ST_RD_WAIT:  state_in = lca_pkg::ST_RESP;
         lca_pkg::ST_ADV_LD0:  state_in = lca_pkg::ST_ADV_LD1;
         lca_pkg::ST_ADV_LD1:  state_in = lca_pkg::ST_ADV_CELL;
         lca_pkg::ST_ADV_CELL: if (last_col) state_in = lca_pkg::ST_ADV_WB;
         lca_pkg::ST_ADV_WB:   state_in = last_row ? lca_pkg::ST_RESP : lca_pkg::ST_ADV_LD1;
         lca_pkg::ST_RESP:     if (rsp_load) state_in = lca_pkg::ST_IDLE;
         default:              state_in = lca_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and memory control
   always_comb begin
      req_tready = (state_ff == lca_pkg::ST_IDLE);
      mem_raddr  = row_ff;
      mem_waddr  = row_ff;
      mem_wdata  = new_ff;
      mem_we     = 1'b0;
      case (state_ff)
         lca_pkg::ST_IDLE: begin
            mem_raddr = (req_op == lca_pkg::OP_ADVANCE) ? '0 : req_row;
         end
         lca_pkg::ST_RD_WAIT: begin
            mem_wdata         = row_data;
            mem_wdata[col_ff] = cell_ff;
            mem_we            = (op_ff == lca_pkg::OP_WRITE);
         end
         lca_pkg::ST_ADV_LD0: mem_raddr = row_plus1[RW-1:0];
         lca_pkg::ST_ADV_WB: begin
            mem_we    = 1'b1;
            mem_raddr = row_plus2[RW-1:0];
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in        = op_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cell_in      = cell_ff;
      res_cell_in  = res_cell_ff;
      res_oor_in   = res_oor_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      next_in      = next_ff;
      next_raw_in  = next_raw_ff;
      new_in       = new_ff;
      row_valid_in = row_valid_ff;
      case (state_ff)
         lca_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in       = req_op;
               col_in      = req_col;
               row_in      = (req_op == lca_pkg::OP_ADVANCE) ? '0 : req_row;
               cell_in     = req_cell;
               res_cell_in = 1'b0;
               res_oor_in  = (req_op == lca_pkg::OP_WRITE || req_op == lca_pkg::OP_READ)
                             && access_oor;
               prev_in     = '0;
               if (req_op == lca_pkg::OP_CLEAR) row_valid_in = '0;
            end
         end
         lca_pkg::ST_RD_WAIT: begin
            if (op_ff == lca_pkg::OP_READ) res_cell_in = row_data[col_ff];
            else row_valid_in[row_ff] = 1'b1;
         end
         lca_pkg::ST_ADV_LD0: begin
            cur_in = row_data & col_mask;
            new_in = row_data;
         end
         lca_pkg::ST_ADV_LD1: begin
            next_in     = next_row_in_area ? (row_data & col_mask) : '0;
            next_raw_in = row_data;
            col_in      = '0;
         end
         lca_pkg::ST_ADV_CELL: begin
            new_in[col_ff] = rule_out;
            col_in         = col_ff + CW'(1);
         end
         lca_pkg::ST_ADV_WB: begin
            row_valid_in[row_ff] = 1'b1;
            // slide the window down one row
            prev_in = cur_ff;
            cur_in  = next_ff;
            new_in  = next_raw_ff;
            row_in  = row_plus1[RW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      cell_ff     <= cell_in;
      res_cell_ff <= res_cell_in;
      res_oor_ff  <= res_oor_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      next_ff     <= next_in;
      next_raw_ff <= next_raw_in;
      new_ff      <= new_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res_oor_ff, res_cell_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   // checks
   a_reset_clears_rows: assert property (@(posedge clock)
      reset |=> row_valid_ff == '0)
      else $error("row valid bits not cleared by reset");

   a_clear_kills_grid: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == lca_pkg::OP_CLEAR) |=> row_valid_ff == '0)
      else $error("clear left a live row");

   a_col_in_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lca_pkg::ST_ADV_CELL) |-> ({1'b0, col_ff} < eff_w))
      else $error("rule unit stepped past the in-use width");

   a_wb_row_in_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lca_pkg::ST_ADV_WB) |-> ({1'b0, row_ff} < eff_h))
      else $error("write-back past the in-use height");

   a_oor_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("out-of-range result carries a cell value");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the life cellular automaton grid unit
// Requests go in as write, read, advance and clear operations over several
// in-use area settings: empty, one cell, small and full, plus register values
// past the grid size. A scoreboard keeps a shadow B3/S23 grid and compares
// every returned cell value and range flag with what the shadow grid predicts.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      bit cell_out;
      bit out_of_range;
   } grid_result_type;

   // Shadow grid, area registers and the queue of results still owed
   class life_grid_scoreboard;
      bit [lca_pkg::MAX_COLS-1:0] cells [lca_pkg::MAX_ROWS];
      int                         area_cols;
      int                         area_rows;
      grid_result_type            owed_q [$];
      int                         mismatches;

      function new();
         foreach (cells[r]) cells[r] = '0;
         area_cols  = 64;
         area_rows  = 64;
         mismatches = 0;
      endfunction

      function int eff_cols();
         return (area_cols > lca_pkg::MAX_COLS) ? lca_pkg::MAX_COLS : area_cols;
      endfunction

      function int eff_rows();
         return (area_rows > lca_pkg::MAX_ROWS) ? lca_pkg::MAX_ROWS : area_rows;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void set_register(logic [lca_pkg::PADDR_W-1:0] addr, logic [31:0] data);
         if (addr == lca_pkg::CSR_ADDR_WIDTH)
            area_cols = int'(data[lca_pkg::CFG_W-1:0]);
         else if (addr == lca_pkg::CSR_ADDR_HEIGHT)
            area_rows = int'(data[lca_pkg::CFG_W-1:0]);
      endfunction

      // Next generation from a copy of the old one; outside the area is dead
      function void step_generation();
         bit [lca_pkg::MAX_COLS-1:0] prior [lca_pkg::MAX_ROWS];
         int cw, rh, live, rr, cc;
         cw    = eff_cols();
         rh    = eff_rows();
         prior = cells;
         for (int r = 0; r < rh; r++) begin
            for (int c = 0; c < cw; c++) begin
               live = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     rr = r + dr;
                     cc = c + dc;
                     if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < rh && cc < cw)
                        live += prior[rr][cc];
                  end
               end
               cells[r][c] = prior[r][c] ? (live == 2 || live == 3) : (live == 3);
            end
         end
      endfunction

      function void note_request(lca_pkg::opcode_type op, logic [lca_pkg::COL_W-1:0] col,
                                 logic [lca_pkg::ROW_W-1:0] row, bit val);
         grid_result_type res;
         res = '0;
         case (op)
            lca_pkg::OP_WRITE, lca_pkg::OP_READ: begin
               if (int'(col) >= eff_cols() || int'(row) >= eff_rows())
                  res.out_of_range = 1'b1;
               else if (op == lca_pkg::OP_WRITE)
                  cells[row][col] = val;
               else
                  res.cell_out = cells[row][col];
            end
            lca_pkg::OP_ADVANCE: step_generation();
            default: foreach (cells[r]) cells[r] = '0;
         endcase
         owed_q.push_back(res);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t ns: %s", $realtime, msg);
      endfunction

      function void check_result(bit cell_out, bit out_of_range);
         grid_result_type want;
         if (owed_q.size() == 0) begin
            flag($sformatf("unexpected result cell_out=%0b out_of_range=%0b",
                           cell_out, out_of_range));
            return;
         end
         want = owed_q.pop_front();
         if (want.cell_out != cell_out || want.out_of_range != out_of_range)
            flag($sformatf("result mismatch: expected cell_out=%0b out_of_range=%0b, got %0b %0b",
                           want.cell_out, want.out_of_range, cell_out, out_of_range));
      endfunction
   endclass

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_tvalid  = 1'b0;
   logic                        req_tready;
   // opcode[1:0], col[7:2], row[13:8], cell_in[14], zero[15]
   logic [15:0]                 req_tdata   = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready  = 1'b0;
   // cell_out[0], out_of_range[1], zero[7:2]
   logic [7:0]                  rsp_tdata;
   logic                        csr_psel    = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite  = 1'b0;
   logic [lca_pkg::PADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                 csr_pwdata  = '0;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   life_grid_scoreboard grid_sb = new();
   bit                  idle_off = 1'b0;
   int                  rsp_hold = 0;

   life_cellular_automaton_grid_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else if (!idle_off && !reset && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = $urandom_range(1, 7) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         grid_sb.check_result(rsp_tdata[0], rsp_tdata[1]);
   end

   task automatic send_req(input lca_pkg::opcode_type op,
                           input logic [lca_pkg::COL_W-1:0] col,
                           input logic [lca_pkg::ROW_W-1:0] row, input bit val);
      if (!idle_off && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, row, col, op};
      do @(posedge clock); while (!req_tready);
      grid_sb.note_request(op, col, row, val);
   endtask

   // Leaves psel high; the caller drops it after the last write
   task automatic csr_write(input logic [lca_pkg::PADDR_W-1:0] addr, input int data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      grid_sb.set_register(addr, data);
   endtask

   // Drain all owed results, then reprogram the in-use area
   task automatic set_area(input int cols_reg, input int rows_reg);
      req_tvalid <= 1'b0;
      while (grid_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(lca_pkg::CSR_ADDR_WIDTH, cols_reg);
      csr_write(lca_pkg::CSR_ADDR_HEIGHT, rows_reg);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random_phase(input int cols_reg, input int rows_reg, input int count);
      int                        ecols, erows, roll, adv_band;
      lca_pkg::opcode_type       op;
      logic [lca_pkg::COL_W-1:0] col;
      logic [lca_pkg::ROW_W-1:0] row;
      bit                        val;
      set_area(cols_reg, rows_reg);
      ecols    = (cols_reg > lca_pkg::MAX_COLS) ? lca_pkg::MAX_COLS : cols_reg;
      erows    = (rows_reg > lca_pkg::MAX_ROWS) ? lca_pkg::MAX_ROWS : rows_reg;
      // keep generations over areas above 256 cells rare, each one visits every cell
      adv_band = (ecols * erows > 256) ? 3 : 12;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         col  = lca_pkg::COL_W'($urandom);
         row  = lca_pkg::ROW_W'($urandom);
         val  = ($urandom_range(0, 9) < 4);
         if (ecols > 0 && erows > 0 && roll < 80) begin
            col = lca_pkg::COL_W'($urandom_range(0, ecols - 1));
            row = lca_pkg::ROW_W'($urandom_range(0, erows - 1));
         end
         if (roll < 45)
            op = lca_pkg::OP_WRITE;
         else if (roll < 80)
            op = lca_pkg::OP_READ;
         else if (roll < 80 + adv_band)
            op = lca_pkg::OP_ADVANCE;
         else if (roll < 82 + adv_band)
            op = lca_pkg::OP_CLEAR;
         else
            op = $urandom_range(0, 1) ? lca_pkg::OP_WRITE : lca_pkg::OP_READ;
         send_req(op, col, row, val);
      end
   endtask

   initial begin
      #25_000_000;
      $display("life_cellular_automaton_grid_unit verification failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full grid: corners, both patterns of bits, lonely cells dying, clear
      set_area(64, 64);
      send_req(lca_pkg::OP_WRITE,   6'd63, 6'd63, 1'b1);
      send_req(lca_pkg::OP_READ,    6'd63, 6'd63, 1'b0);
      send_req(lca_pkg::OP_READ,    6'd0,  6'd0,  1'b0);
      send_req(lca_pkg::OP_WRITE,   6'd0,  6'd0,  1'b1);
      send_req(lca_pkg::OP_READ,    6'd0,  6'd0,  1'b0);
      send_req(lca_pkg::OP_ADVANCE, 6'd0,  6'd0,  1'b0);
      send_req(lca_pkg::OP_READ,    6'd63, 6'd63, 1'b0);
      send_req(lca_pkg::OP_WRITE,   6'd21, 6'd42, 1'b1);
      send_req(lca_pkg::OP_READ,    6'd21, 6'd42, 1'b0);
      send_req(lca_pkg::OP_CLEAR,   6'd42, 6'd21, 1'b1);
      send_req(lca_pkg::OP_READ,    6'd21, 6'd42, 1'b0);

      // small area: blinker turns vertical, accesses past the edge
      set_area(5, 5);
      send_req(lca_pkg::OP_WRITE,   6'd1, 6'd2, 1'b1);
      send_req(lca_pkg::OP_WRITE,   6'd2, 6'd2, 1'b1);
      send_req(lca_pkg::OP_WRITE,   6'd3, 6'd2, 1'b1);
      send_req(lca_pkg::OP_ADVANCE, 6'd0, 6'd0, 1'b0);
      send_req(lca_pkg::OP_READ,    6'd2, 6'd1, 1'b0);
      send_req(lca_pkg::OP_READ,    6'd1, 6'd2, 1'b0);
      send_req(lca_pkg::OP_WRITE,   6'd5, 6'd0, 1'b1);
      send_req(lca_pkg::OP_READ,    6'd0, 6'd5, 1'b0);

      // empty area: every access out of range, advance does nothing
      set_area(0, 0);
      send_req(lca_pkg::OP_READ,    6'd0, 6'd0, 1'b0);
      send_req(lca_pkg::OP_ADVANCE, 6'd0, 6'd0, 1'b0);
      send_req(lca_pkg::OP_WRITE,   6'd0, 6'd0, 1'b1);

      // register values past the grid size saturate
      set_area(100, 127);
      send_req(lca_pkg::OP_READ,    6'd2,  6'd1,  1'b0);
      send_req(lca_pkg::OP_READ,    6'd63, 6'd63, 1'b0);

      run_random_phase(6, 6, 18);
      run_random_phase(64, 64, 16);
      run_random_phase(3, 8, 18);
      run_random_phase(0, 5, 8);
      run_random_phase(127, 2, 14);
      run_random_phase(1, 1, 10);
      run_random_phase(10, 7, 12);
      run_random_phase(5, 0, 6);
      idle_off = 1'b1;
      run_random_phase(8, 8, 14);

      req_tvalid <= 1'b0;
      while (grid_sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (grid_sb.mismatches == 0 && grid_sb.pending() == 0)
         $display("life_cellular_automaton_grid_unit verification clean");
      else
         $display("life_cellular_automaton_grid_unit verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/lca_pkg.sv
rtl/life_cellular_automaton_grid_unit.sv
tb/sv/tb.sv
